/* src/crlb_pkg.sv */
package crlb_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 64;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_ATTACHED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR    = 2'd2;

  localparam logic [CHAR_W-1:0] ERASE_CHAR_RST = 8'h08;

  localparam logic [CHAR_W-1:0] CH_ESC     = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_B = 8'h42;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_LINE_END = 2'd1,
    EV_CURS_UP  = 2'd2,
    EV_CURS_DN  = 2'd3
  } event_t;

  // what the back end has to do with one word
  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_ERASE   = 3'd1,
    OP_STORE   = 3'd2,
    OP_SWALLOW = 3'd3,
    OP_UP      = 3'd4,
    OP_DN      = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  typedef struct packed {
    logic              command;
    logic [CHAR_W-1:0] rx_char;
  } in_word_t;

  typedef struct packed {
    logic              tx_valid;
    logic [CHAR_W-1:0] tx_char;
    logic [1:0]        event_res;
    logic              dropped;
    logic              read_valid;
    logic [CHAR_W-1:0] read_char;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } out_word_t;

endpackage

/* src/crlb_front.sv */
module crlb_front import crlb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_word_t          in_word,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] erase_char,
  input  logic              q_full,
  output logic              q_push,
  output op_t               q_op
);

  typedef enum logic [4:0] {
    ES_IDLE    = 5'b00001,
    ES_GOT_ESC = 5'b00010,
    ES_GOT_BRK = 5'b00100,
    ES_AFT_UP  = 5'b01000,
    ES_AFT_DN  = 5'b10000
  } esc_state_t;

  esc_state_t esc_r, esc_nxt;
  esc_state_t esc_parse;
  op_kind_t   parse_kind;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // escape parser for a plain received byte
  always_comb begin
    esc_parse  = ES_IDLE;
    parse_kind = OP_STORE;
    unique case (esc_r) inside
      ES_IDLE, ES_AFT_UP, ES_AFT_DN: begin
        if (in_word.rx_char == CH_ESC) begin
          esc_parse  = ES_GOT_ESC;
          parse_kind = OP_SWALLOW;
        end
      end
      ES_GOT_ESC: begin
        if (in_word.rx_char == CH_LBRACK) begin
          esc_parse  = ES_GOT_BRK;
          parse_kind = OP_SWALLOW;
        end
      end
      ES_GOT_BRK: begin
        if (in_word.rx_char == CH_UPPER_A) begin
          esc_parse  = ES_AFT_UP;
          parse_kind = OP_UP;
        end else if (in_word.rx_char == CH_UPPER_B) begin
          esc_parse  = ES_AFT_DN;
          parse_kind = OP_DN;
        end
      end
      default: begin
        esc_parse  = ES_IDLE;
        parse_kind = OP_STORE;
      end
    endcase
  end

  // erase match wins over any escape meaning and leaves the parser alone
  always_comb begin
    esc_nxt    = esc_r;
    q_op.ch    = in_word.rx_char;
    q_op.kind  = parse_kind;
    if (in_word.command == CMD_READ) begin
      q_op.kind = OP_READ;
    end else if (in_word.rx_char == erase_char) begin
      q_op.kind = OP_ERASE;
    end else if (accept) begin
      esc_nxt = esc_parse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= ES_IDLE;
    end else begin
      esc_r <= esc_nxt;
    end
  end

endmodule

/* src/crlb_opq.sv */
module crlb_opq import crlb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t        slot_r [2];
  logic       wr_sel_r, rd_sel_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_op    = slot_r[rd_sel_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_sel_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_sel_r <= !wr_sel_r;
      end
      if (do_pop) begin
        rd_sel_r <= !rd_sel_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

/* src/crlb_back.sv */
module crlb_back import crlb_pkg::*; #(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  input  logic      echo_enable,
  input  logic      task_attached,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    BK_EXEC  = 4'b0001,
    BK_RDATA = 4'b0010,
    BK_ERA1  = 4'b0100,
    BK_ERA2  = 4'b1000
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_r;
  logic [PTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              mem_we, rd_en;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  out_word_t         res;
  logic              load, out_free;
  logic [PTR_W-1:0]  wr_inc, wr_dec, rd_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign wr_inc = (wr_r == PTR_LAST) ? '0 : wr_r + 1'b1;
  assign wr_dec = (wr_r == '0) ? PTR_LAST : wr_r - 1'b1;
  assign rd_inc = (rd_r == PTR_LAST) ? '0 : rd_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    res       = '0;
    fill_nxt  = fill_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    mem_we    = 1'b0;
    rd_en     = 1'b0;

    unique case (state_r)
      BK_EXEC: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          res.last = 1'b1;
          unique case (q_op.kind)
            OP_READ: begin
              if (fill_r != '0) begin
                rd_en     = 1'b1;
                rd_nxt    = rd_inc;
                fill_nxt  = fill_r - 1'b1;
                state_nxt = BK_RDATA;
              end else begin
                load = 1'b1;
              end
            end
            OP_ERASE: begin
              load = 1'b1;
              if (fill_r != '0) begin
                wr_nxt       = wr_dec;
                fill_nxt     = fill_r - 1'b1;
                res.last     = 1'b0;
                res.tx_valid = 1'b1;
                if (echo_enable) begin
                  res.tx_char = CH_BS;
                  state_nxt   = BK_ERA1;
                end else begin
                  res.tx_char = CH_SPACE;
                  state_nxt   = BK_ERA2;
                end
              end
            end
            default: begin
              // plain or escape byte: echo, then act
              load         = 1'b1;
              res.tx_valid = echo_enable;
              res.tx_char  = echo_enable ? q_op.ch : '0;
              if (q_op.kind == OP_UP) begin
                res.event_res = EV_CURS_UP;
              end else if (q_op.kind == OP_DN) begin
                res.event_res = EV_CURS_DN;
              end else if (q_op.kind == OP_STORE) begin
                if (fill_r == CNT_FULL) begin
                  res.dropped = 1'b1;
                end else begin
                  mem_we   = 1'b1;
                  wr_nxt   = wr_inc;
                  fill_nxt = fill_r + 1'b1;
                  if (task_attached && (q_op.ch == CH_CR || q_op.ch == CH_LF)) begin
                    res.event_res = EV_LINE_END;
                  end
                end
              end
            end
          endcase
        end
      end
      BK_RDATA: begin
        if (out_free) begin
          load           = 1'b1;
          res.read_valid = 1'b1;
          res.read_char  = rdata_r;
          res.last       = 1'b1;
          state_nxt      = BK_EXEC;
        end
      end
      BK_ERA1: begin
        if (out_free) begin
          load         = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_char  = CH_SPACE;
          state_nxt    = BK_ERA2;
        end
      end
      BK_ERA2: begin
        if (out_free) begin
          load         = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_char  = CH_BS;
          res.last     = 1'b1;
          state_nxt    = BK_EXEC;
        end
      end
      default: begin
        state_nxt = BK_EXEC;
      end
    endcase

    res.fill_level = FILL_W'(fill_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r] <= q_op.ch;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_EXEC;
      wr_r        <= '0;
      rd_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/console_rx_line_buffer_top.sv */
// Console receive line buffer.
// Input channel (in_valid / in_stall / in_word): one word is either a received
// UART byte (command 0) or a read request (command 1). Output channel
// (out_valid / out_stall / out_word): result words; each input word gives one
// result, an effective erase gives two (echo off) or three (echo on), and
// the final result of a word has last set.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 echo enable,
// 1 task attached, 2 erase char); write only while the block is idle.
// Timing: a byte passes through the op queue and the result register; a read
// also passes through the registered line store read. Plain and escape bytes run
// at one word per cycle while the receiver does not stall; a read holds the
// executor in BK_RDATA, and an erase holds it until its last echoed byte.
// Reset (rst_n low, synchronous) empties the buffer, returns the escape
// parser to idle and loads the config defaults. The line store itself is
// not cleared; only written bytes are ever read back.
// When the receiver stalls, the result register holds, the executor stops,
// and the two-deep op queue fills, after which in_stall rises.
module console_rx_line_buffer_top import crlb_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_word_t              in_word,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic              echo_r, task_r;
  logic [CHAR_W-1:0] erase_r;

  logic q_push, q_full, q_pop, q_valid;
  op_t  push_op, head_op;

  // config registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r  <= 1'b0;
      task_r  <= 1'b1;
      erase_r <= ERASE_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ECHO_ENABLE:   echo_r  <= cfg_wdata[0];
        CFG_TASK_ATTACHED: task_r  <= cfg_wdata[0];
        CFG_ERASE_CHAR:    erase_r <= cfg_wdata[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: erase match, read decode and escape parsing
  crlb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .erase_char (erase_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_op       (push_op)
  );

  // decouples the parser from the buffer executor
  crlb_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  // back: ring buffer, fill count, echo sequencing, result register
  crlb_back #(
    .DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_op          (head_op),
    .q_pop         (q_pop),
    .echo_enable   (echo_r),
    .task_attached (task_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word)
  );

endmodule

/* src/crlb_checker.sv */
module crlb_checker import crlb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a popped byte is the whole answer to a read
  a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.read_valid |-> out_word.last && !out_word.tx_valid
      && out_word.event_res == EV_NONE && !out_word.dropped)
    else $error("read result carries other fields");

  // a dropped byte raises no event
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.dropped |-> out_word.event_res == EV_NONE
      && !out_word.read_valid)
    else $error("dropped byte with event");

  // only erase echo makes non-final results
  a_erase_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> out_word.tx_valid
      && (out_word.tx_char == CH_BS || out_word.tx_char == CH_SPACE))
    else $error("bad erase echo");

endmodule

bind console_rx_line_buffer_top crlb_checker u_crlb_checker (.*);

/* verif/console_rx_line_buffer_checker.sv */
module console_rx_line_buffer_checker import crlb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = BUFFER_DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_AFTER_UP,
    ESC_AFTER_DN
  } esc_state_t;

  logic [CHAR_W-1:0] line_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill_cnt;
  esc_state_t        esc_st;
  logic              echo_on;
  logic              attached;
  logic [CHAR_W-1:0] erase_ch;

  out_word_t console_results_q [$];

  initial begin
    fail_count = 0;
    results_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // line discipline on one word; queues the result words it gives
  task automatic run_line_discipline(input in_word_t w);
    out_word_t r;
    op_kind_t  parsed;
    r = '0;
    if (w.command == CMD_READ) begin
      if (fill_cnt != 0) begin
        r.read_valid = 1'b1;
        r.read_char  = line_mem[rd_ptr];
        rd_ptr       = rd_ptr + 1'b1;
        fill_cnt     = fill_cnt - 1'b1;
      end
      r.fill_level = fill_cnt;
      r.last       = 1'b1;
      console_results_q.push_back(r);
    end else if (w.rx_char == erase_ch) begin
      // erase never touches the escape parser
      if (fill_cnt == 0) begin
        r.last = 1'b1;
        console_results_q.push_back(r);
      end else begin
        wr_ptr       = wr_ptr - 1'b1;
        fill_cnt     = fill_cnt - 1'b1;
        r.fill_level = fill_cnt;
        r.tx_valid   = 1'b1;
        if (echo_on) begin
          r.tx_char = CH_BS;
          console_results_q.push_back(r);
        end
        r.tx_char = CH_SPACE;
        console_results_q.push_back(r);
        r.tx_char = CH_BS;
        r.last    = 1'b1;
        console_results_q.push_back(r);
      end
    end else begin
      if (w.rx_char == CH_ESC && esc_st inside {ESC_IDLE, ESC_AFTER_UP, ESC_AFTER_DN}) begin
        parsed = OP_SWALLOW;
        esc_st = ESC_SEEN;
      end else if (w.rx_char == CH_LBRACK && esc_st == ESC_SEEN) begin
        parsed = OP_SWALLOW;
        esc_st = ESC_BRACKET;
      end else if (w.rx_char == CH_UPPER_A && esc_st == ESC_BRACKET) begin
        parsed = OP_UP;
        esc_st = ESC_AFTER_UP;
      end else if (w.rx_char == CH_UPPER_B && esc_st == ESC_BRACKET) begin
        parsed = OP_DN;
        esc_st = ESC_AFTER_DN;
      end else begin
        parsed = OP_STORE;
        esc_st = ESC_IDLE;
      end
      r.tx_valid = echo_on;
      r.tx_char  = echo_on ? w.rx_char : '0;
      case (parsed)
        OP_UP: r.event_res = EV_CURS_UP;
        OP_DN: r.event_res = EV_CURS_DN;
        OP_STORE: begin
          if (fill_cnt >= DEPTH) begin
            r.dropped = 1'b1;
          end else begin
            line_mem[wr_ptr] = w.rx_char;
            wr_ptr           = wr_ptr + 1'b1;
            fill_cnt         = fill_cnt + 1'b1;
            if (attached && (w.rx_char == CH_CR || w.rx_char == CH_LF))
              r.event_res = EV_LINE_END;
          end
        end
        default: ;
      endcase
      r.fill_level = fill_cnt;
      r.last       = 1'b1;
      console_results_q.push_back(r);
    end
  endtask

  task automatic compare_result(input out_word_t got);
    out_word_t want;
    if (console_results_q.size() == 0) begin
      report_mismatch("result word with none pending", 32'(got), '0);
      return;
    end
    want = console_results_q.pop_front();
    if (got.tx_valid !== want.tx_valid)
      report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
    if (got.tx_char !== want.tx_char)
      report_mismatch("tx_char", 32'(got.tx_char), 32'(want.tx_char));
    if (got.event_res !== want.event_res)
      report_mismatch("event_res", 32'(got.event_res), 32'(want.event_res));
    if (got.dropped !== want.dropped)
      report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
    if (got.read_valid !== want.read_valid)
      report_mismatch("read_valid", 32'(got.read_valid), 32'(want.read_valid));
    if (got.read_char !== want.read_char)
      report_mismatch("read_char", 32'(got.read_char), 32'(want.read_char));
    if (got.fill_level !== want.fill_level)
      report_mismatch("fill_level", 32'(got.fill_level), 32'(want.fill_level));
    if (got.last !== want.last)
      report_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr   = '0;
      rd_ptr   = '0;
      fill_cnt = '0;
      esc_st   = ESC_IDLE;
      echo_on  = 1'b0;
      attached = 1'b1;
      erase_ch = ERASE_CHAR_RST;
      console_results_q.delete();
    end else begin
      if (out_valid && !out_stall)
        compare_result(out_word);
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ECHO_ENABLE:   echo_on  = cfg_wdata[0];
          CFG_TASK_ATTACHED: attached = cfg_wdata[0];
          CFG_ERASE_CHAR:    erase_ch = cfg_wdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        run_line_discipline(in_word);
    end
    results_pending = console_results_q.size();
  end

endmodule

/* verif/console_rx_line_buffer_top_tb.sv */
module console_rx_line_buffer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crlb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  in_word_t              in_word;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int results_pending;

  // idle odds in percent, per side; changed between phases
  int send_idle_pct = 35;
  int recv_idle_pct = 84;

  // long receiver hold-off: stimulus posts a length, receiver counts it down
  int hold_off_req = 0;
  int hold_left    = 0;

  int words_sent = 0;
  int phase_goal;
  int burst;
  logic [CHAR_W-1:0] cur_erase;

  console_rx_line_buffer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  console_rx_line_buffer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; far beyond the slowest legal run
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // Receiver side. Stalls drawn per cycle, except while a hold-off runs.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offer one word and wait for the handshake. Called and returns at a
  // falling edge; valid is left high so back-to-back words need no gap.
  task automatic send_word(input logic cmd, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{command: cmd, rx_char: ch};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Drop valid, let every pending result word out, then let the block settle
  // to idle before returning.
  task automatic await_idle();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // All three registers, one write per cycle, only with the block idle.
  task automatic set_config(input logic echo_en, input logic attach,
                            input logic [CHAR_W-1:0] erase);
    await_idle();
    cur_erase = erase;
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ECHO_ENABLE;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, echo_en};
    @(negedge clk);
    cfg_addr  <= CFG_TASK_ATTACHED;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, attach};
    @(negedge clk);
    cfg_addr  <= CFG_ERASE_CHAR;
    cfg_wdata <= erase;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    cur_erase = ERASE_CHAR_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed, reset config: echo off, task attached, erase = BS ---
    send_word(CMD_READ, 8'hFF);        // read with buffer empty
    send_word(CMD_RX, CH_BS);          // erase with buffer empty
    send_word(CMD_RX, 8'h00);
    send_word(CMD_RX, 8'hFF);
    send_word(CMD_RX, CH_CR);          // line end
    send_word(CMD_RX, CH_LF);
    send_word(CMD_RX, CH_ESC);         // cursor up
    send_word(CMD_RX, CH_LBRACK);
    send_word(CMD_RX, CH_UPPER_A);
    send_word(CMD_RX, CH_ESC);         // cursor down, straight after up
    send_word(CMD_RX, CH_LBRACK);
    send_word(CMD_RX, CH_UPPER_B);
    send_word(CMD_RX, CH_ESC);         // ESC inside a sequence gets stored
    send_word(CMD_RX, CH_ESC);
    send_word(CMD_RX, CH_LBRACK);      // lone bracket is plain data
    send_word(CMD_RX, CH_ESC);         // broken sequence: last byte stored
    send_word(CMD_RX, CH_LBRACK);
    send_word(CMD_RX, 8'h58);
    send_word(CMD_RX, CH_BS);          // erase, echo off: space BS
    send_word(CMD_READ, 8'h00);
    send_word(CMD_READ, 8'h00);

    // echo on, no task, erase = DEL
    set_config(1'b1, 1'b0, 8'h7F);
    send_word(CMD_RX, 8'h7F);          // erase with echo: BS space BS
    send_word(CMD_RX, CH_CR);          // stored, but no line-end event
    send_word(CMD_RX, CH_ESC);
    send_word(CMD_RX, 8'h7F);          // erase mid-sequence keeps parser state
    send_word(CMD_RX, CH_LBRACK);
    send_word(CMD_RX, CH_UPPER_B);

    // --- back-pressure: receiver holds off while the sender streams in ---
    set_config(1'b0, 1'b1, CH_BS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 300;
    repeat (70) send_word(CMD_RX, 8'($urandom_range(8'h61, 8'h7A)));  // overflows
    send_word(CMD_RX, CH_ESC);         // cursor event while full
    send_word(CMD_RX, CH_LBRACK);
    send_word(CMD_RX, CH_UPPER_A);
    send_word(CMD_RX, CH_CR);          // full: dropped, no line end
    send_word(CMD_RX, CH_BS);
    repeat (66) send_word(CMD_READ, 8'($urandom));  // drain past empty

    // --- random phases: idle sender/stalling receiver, reversed, none ---
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 84;
          set_config(1'b1, 1'b1, 8'hFF);
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 35;
          set_config(1'b0, 1'b0, 8'h00);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? CH_BS : 8'h7F);
        end
      endcase
      phase_goal = words_sent + 87;
      while (words_sent < phase_goal) begin
        burst = $urandom_range(1, 12);
        case ($urandom_range(0, 9)) inside
          [0:2]: repeat (burst) send_word(CMD_READ, 8'($urandom));
          3: begin
            // mostly well-formed cursor sequences, some broken ones
            send_word(CMD_RX, CH_ESC);
            if ($urandom_range(0, 4) != 0) send_word(CMD_RX, CH_LBRACK);
            case ($urandom_range(0, 3))
              0: send_word(CMD_RX, CH_UPPER_A);
              1: send_word(CMD_RX, CH_UPPER_B);
              2: send_word(CMD_RX, CH_ESC);
              default: send_word(CMD_RX, 8'($urandom));
            endcase
          end
          4: repeat ($urandom_range(1, 4)) send_word(CMD_RX, cur_erase);
          5: send_word(CMD_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
          default: repeat (burst) send_word(CMD_RX, 8'($urandom));
        endcase
      end
    end

    await_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
src/crlb_pkg.sv
src/crlb_front.sv
src/crlb_opq.sv
src/crlb_back.sv
src/console_rx_line_buffer_top.sv
src/crlb_checker.sv
verif/console_rx_line_buffer_checker.sv
verif/console_rx_line_buffer_top_tb.sv
